// ===== rtl/size_class_block_pool_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef SIZE_CLASS_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_POOL_ALLOCATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SCBPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SCBPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/scbpa_pkg.sv =====
// Package with types, codes and constants of the block pool allocator.
`default_nettype none
package scbpa_pkg;
  localparam int NUM_POOLS_DEF = 4;
  localparam int SLOTS_PER_POOL_DEF = 64;
  localparam int MAX_POOLS = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_POOL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESC0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESC3 = 3'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [1:0]  pool_number;
    logic [5:0]  slot_number;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, evaluate pools
    logic div_start;  // begin the slot division
    logic div_step;   // one restoring division step
    logic commit;     // update bitmap and result
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;   // free command hit a pool
    logic div_last;   // last division step in progress
  } ctl_sts_t;
endpackage
`default_nettype wire

// ===== rtl/scbpa_ctrl.sv =====
// Controller state machine of the block pool allocator.
`default_nettype none
`include "size_class_block_pool_allocator_macros.svh"
module scbpa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      out_valid,
  output scbpa_pkg::ctl_cmd_t       cmd,
  input  wire scbpa_pkg::ctl_sts_t  sts
);
  import scbpa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] S_GRANT = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_GRANT;
        end
      end
      // The selected pool is registered now; the grant address settles here.
      S_GRANT: state_nxt = S_COMMIT;
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  `SCBPA_ASSERT_NXT(a_load_eval, clk, rst_n, cmd.load, state_r == S_EVAL, "load not followed by evaluation")
  `SCBPA_ASSERT_NXT(a_commit_out, clk, rst_n, cmd.commit, out_valid, "commit not followed by result")
  `SCBPA_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd), "more than one command at once")
endmodule
`default_nettype wire

// ===== rtl/scbpa_dp.sv =====
// Datapath: configuration registers, bitmaps, pool selection and divider.
`default_nettype none
`include "size_class_block_pool_allocator_macros.svh"
module scbpa_dp #(
  parameter int NUM_POOLS = scbpa_pkg::NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL = scbpa_pkg::SLOTS_PER_POOL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [scbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire scbpa_pkg::req_t                   in_req,
  input  wire scbpa_pkg::ctl_cmd_t               cmd,
  output scbpa_pkg::ctl_sts_t                    sts,
  output scbpa_pkg::rsp_t                        rsp
);
  import scbpa_pkg::*;

  localparam int SW = 6;
  localparam int PW = 2;
  localparam logic [6:0] SLOT_LIMIT = 7'(SLOTS_PER_POOL);

  logic [MAX_POOLS-1:0] en_r;
  logic [63:0] desc_r [MAX_POOLS];
  logic [SLOTS_PER_POOL-1:0] map_r [NUM_POOLS];
  req_t req_r;
  rsp_t rsp_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
      for (int i = 0; i < MAX_POOLS; i++) desc_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENABLE) en_r <= cfg_data[MAX_POOLS-1:0];
      else if (cfg_index >= REG_DESC0 && cfg_index <= REG_DESC3)
        desc_r[2'(cfg_index - REG_DESC0)] <= cfg_data;
    end
  end

  // Per-pool fields, saturated count and range checks.
  logic [31:0] base [NUM_POOLS];
  logic [15:0] bsize [NUM_POOLS];
  logic [6:0]  cnt [NUM_POOLS];
  logic [NUM_POOLS-1:0] usable;
  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      base[p] = desc_r[p][63:32];
      bsize[p] = desc_r[p][31:16];
      cnt[p] = (desc_r[p][15:0] > 16'(SLOTS_PER_POOL)) ? SLOT_LIMIT : desc_r[p][6:0];
      usable[p] = en_r[p] && (bsize[p] >= req_r.request_size);
    end
  end

  // Range check uses a registered span to keep multipliers out of the compare path.
  logic [38:0] span_r [NUM_POOLS];
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_POOLS; p++) span_r[p] <= 39'(bsize[p] * cnt[p]);
  end

  logic [NUM_POOLS-1:0] hit;
  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      hit[p] = usable[p] && bsize[p] != 16'd0 && req_r.block_address >= base[p] &&
               ({7'd0, req_r.block_address} < ({7'd0, base[p]} + span_r[p]));
    end
  end

  // First usable pool for allocate, first hit pool for free.
  logic [PW-1:0] sel_p;
  logic          sel_ok;
  always_comb begin
    sel_p = '0;
    sel_ok = 1'b0;
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (req_r.command == CMD_ALLOC ? usable[p] : hit[p]) begin
        sel_p = PW'(p);
        sel_ok = 1'b1;
      end
    end
  end

  // First free slot of the selected pool.
  logic [SW-1:0] free_s;
  logic          free_ok;
  always_comb begin
    free_s = '0;
    free_ok = 1'b0;
    for (int s = SLOTS_PER_POOL - 1; s >= 0; s--) begin
      if (!map_r[sel_p][s] && 7'(s) < cnt[sel_p]) begin
        free_s = SW'(s);
        free_ok = 1'b1;
      end
    end
  end

  // Selection registered in each cycle except during a division step.
  logic [PW-1:0] p_r;
  logic          ok_r;
  logic [SW-1:0] fs_r;
  logic          fok_r;
  always_ff @(posedge clk) begin
    if (cmd.div_start || !cmd.div_step) begin
      p_r <= sel_p;
      ok_r <= sel_ok;
      fs_r <= free_s;
      fok_r <= free_ok;
    end
  end

  // Restoring divider: (address - base) / size, one quotient bit a step.
  logic [31:0] dividend_r, quot_r;
  logic [15:0] divisor_r;
  logic [16:0] rem_r;
  logic [4:0]  step_r;
  logic [16:0] trial;
  assign trial = {rem_r[15:0], dividend_r[31]} - {1'b0, divisor_r};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend_r <= req_r.block_address - base[sel_p];
      divisor_r <= bsize[sel_p];
      rem_r <= '0;
      quot_r <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      dividend_r <= {dividend_r[30:0], 1'b0};
      step_r <= step_r + 5'd1;
      if (!trial[16]) begin
        rem_r <= trial;
        quot_r <= {quot_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], dividend_r[31]};
        quot_r <= {quot_r[30:0], 1'b0};
      end
    end
  end

  assign sts.need_div = (req_r.command == CMD_FREE) && sel_ok;
  assign sts.div_last = (step_r == 5'd31);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
  end

  // Grant address multiply, registered before the commit.
  logic [31:0] grant_r;
  always_ff @(posedge clk) begin
    grant_r <= base[p_r] + 32'(32'(fs_r) * 32'(bsize[p_r]));
  end

  // Bitmap update and result.
  logic [1:0] wr_ok;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) map_r[p] <= '0;
    end else if (cfg_we && cfg_index >= REG_DESC0 && cfg_index <= REG_DESC3) begin
      for (int p = 0; p < NUM_POOLS; p++)
        if (32'(cfg_index - REG_DESC0) == p) map_r[p] <= '0;
    end else if (cmd.commit && ok_r) begin
      if (req_r.command == CMD_ALLOC) begin
        if (fok_r) map_r[p_r][fs_r] <= 1'b1;
      end else if (quot_r < 32'(cnt[p_r])) begin
        map_r[p_r][SW'(quot_r)] <= 1'b0;
      end
    end
  end
  assign wr_ok = '0;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_r <= '0;
      if (req_r.command == CMD_ALLOC) begin
        if (!ok_r) rsp_r.status <= ST_NO_POOL;
        else begin
          rsp_r.pool_number <= p_r;
          if (fok_r) begin
            rsp_r.status <= ST_DONE;
            rsp_r.slot_number <= fs_r;
            rsp_r.granted_address <= grant_r;
          end else rsp_r.status <= ST_FULL;
        end
      end else if (!ok_r) begin
        rsp_r.status <= ST_NOT_FOUND;
      end else begin
        rsp_r.status <= ST_DONE | wr_ok;
        rsp_r.pool_number <= p_r;
        if (quot_r < 32'(cnt[p_r])) rsp_r.slot_number <= SW'(quot_r);
      end
    end
  end
  assign rsp = rsp_r;

  `SCBPA_ASSERT_NXT(a_div_quot, clk, rst_n, cmd.div_start, step_r == 5'd0, "divider not cleared")
  `SCBPA_ASSERT_IMP(a_free_nogrant, clk, rst_n, cmd.commit && req_r.command == CMD_FREE, !cmd.div_step, "step during commit")
  `SCBPA_ASSERT_IMP(a_alloc_nodiv, clk, rst_n, cmd.div_start, req_r.command == CMD_FREE, "division started on allocate")
endmodule
`default_nettype wire

// ===== rtl/size_class_block_pool_allocator.sv =====
// Top level of the size-class block pool allocator.
//
// Usage: pulse start with in_req (command, request_size, block_address)
// while busy is low. An allocate takes the first enabled pool whose block
// size fits the request, marks its lowest free slot and returns the
// address. A free finds the pool holding the address and clears its slot.
// Each request yields one result on out_rsp, shown for one cycle with
// out_valid high; the receiver cannot stall it and must take it then.
// Sequence: an allocate, or a free that matches no pool, steps through the
// evaluate, grant, commit and output states; a free that hits a pool steps
// through evaluate, the bit-serial 32-step divider that computes the slot
// index, commit and output.
// A new request can be accepted the cycle after the result strobe.
// Configuration: cfg_we writes cfg_data to register cfg_index (index 0 the
// pool enable mask, 1 to 4 the descriptors); the user must write while the
// block is idle; the block does not enforce it. A descriptor write clears
// its bitmap. Reset clears configuration and bitmaps and returns to idle.
`default_nettype none
module size_class_block_pool_allocator #(
  parameter int NUM_POOLS = scbpa_pkg::NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL = scbpa_pkg::SLOTS_PER_POOL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire scbpa_pkg::req_t                   in_req,
  output logic                                   out_valid,
  output scbpa_pkg::rsp_t                        out_rsp,
  input  wire logic                              cfg_we,
  input  wire logic [scbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scbpa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  scbpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .sts(sts)
  );

  scbpa_dp #(.NUM_POOLS(NUM_POOLS), .SLOTS_PER_POOL(SLOTS_PER_POOL)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_req(in_req), .cmd(cmd), .sts(sts), .rsp(out_rsp)
  );
endmodule
`default_nettype wire

// ===== tb/scbpa_checker.sv =====
// Checker that predicts allocator responses and compares them with the block's output.
`default_nettype none
module scbpa_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             busy,
  input  wire scbpa_pkg::req_t                  in_req,
  input  wire logic                             out_valid,
  input  wire scbpa_pkg::rsp_t                  out_rsp,
  input  wire logic                             cfg_we,
  input  wire logic [scbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                    mismatches,
  output int                                    pending
);
  import scbpa_pkg::*;

  logic [3:0]  enable_mask;
  logic [63:0] pool_desc [4];
  logic [63:0] in_use [4];
  rsp_t        expected_rsp [$];

  assign pending = expected_rsp.size();

  // Print one line for a mismatch and count it.
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Work out the response to one request and update the slot maps.
  function automatic rsp_t allocate_or_free(input req_t r);
    rsp_t   rsp;
    logic [31:0] base;
    logic [15:0] bsize;
    logic [6:0]  cnt;
    logic [63:0] last_end;
    logic [63:0] slot;
    rsp = '0;
    rsp.status = (r.command == CMD_ALLOC) ? ST_NO_POOL : ST_NOT_FOUND;
    for (int p = 0; p < 4; p++) begin
      base  = pool_desc[p][63:32];
      bsize = pool_desc[p][31:16];
      cnt   = (pool_desc[p][15:0] > 64) ? 7'd64 : pool_desc[p][6:0];
      if (!enable_mask[p] || bsize < r.request_size) continue;
      if (r.command == CMD_ALLOC) begin
        rsp.status = ST_FULL;
        rsp.pool_number = p[1:0];
        for (int s = 0; s < cnt; s++) begin
          if (!in_use[p][s]) begin
            in_use[p][s] = 1'b1;
            rsp.status = ST_DONE;
            rsp.slot_number = s[5:0];
            rsp.granted_address = base + s * bsize;
            break;
          end
        end
        break;
      end else begin
        last_end = {32'd0, base} + 64'(bsize) * 64'(cnt);
        if (64'(r.block_address) >= 64'(base) && 64'(r.block_address) < last_end
            && bsize != 0) begin
          slot = 64'(r.block_address - base) / 64'(bsize);
          if (slot < cnt) begin
            in_use[p][slot[5:0]] = 1'b0;
            rsp.slot_number = slot[5:0];
          end
          rsp.status = ST_DONE;
          rsp.pool_number = p[1:0];
          break;
        end
      end
    end
    return rsp;
  endfunction

  // Track configuration, queue predictions and compare responses.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      enable_mask <= '0;
      for (int p = 0; p < 4; p++) begin
        pool_desc[p] = '0;
        in_use[p] = '0;
      end
      expected_rsp.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ENABLE) enable_mask <= cfg_data[3:0];
        else if (cfg_index >= REG_DESC0 && cfg_index <= REG_DESC3) begin
          pool_desc[cfg_index - REG_DESC0] = cfg_data;
          in_use[cfg_index - REG_DESC0] = '0;
        end
      end
      if (out_valid) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected response", 32'(out_rsp.status), 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp.status != want.status)
            report("status", 32'(out_rsp.status), 32'(want.status));
          if (out_rsp.granted_address != want.granted_address)
            report("granted_address", out_rsp.granted_address, want.granted_address);
          if (out_rsp.pool_number != want.pool_number)
            report("pool_number", 32'(out_rsp.pool_number), 32'(want.pool_number));
          if (out_rsp.slot_number != want.slot_number)
            report("slot_number", 32'(out_rsp.slot_number), 32'(want.slot_number));
        end
      end
      if (start && !busy) expected_rsp.push_back(allocate_or_free(in_req));
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_size_class_block_pool_allocator.sv =====
// Testbench top: drives requests and configuration and gives the verdict.
`default_nettype none
module tb_size_class_block_pool_allocator;
  import scbpa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int mismatches;
  int pending;
  int cycles = 0;
  int idle_pct = 13;
  logic [63:0] desc_now [4];

  always #1 clk = ~clk;

  size_class_block_pool_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scbpa_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .mismatches(mismatches),
    .pending(pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Wait for all responses plus the longest request latency.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx >= REG_DESC0 && idx <= REG_DESC3) desc_now[idx - REG_DESC0] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Issue one request, holding start until it is accepted.
  task automatic send(input logic cmd, input logic [15:0] sz, input logic [31:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start <= 1'b1;
    in_req <= '{command: cmd, request_size: sz, block_address: addr};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Random request that mostly targets a configured pool.
  task automatic random_request();
    int p;
    logic [63:0] d;
    logic [31:0] addr;
    logic [15:0] sz;
    p = $urandom_range(3);
    d = desc_now[p];
    sz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(d[31:16]));
    addr = d[63:32] + d[31:16] * $urandom_range(70) + $urandom_range(3);
    if ($urandom_range(9) == 0) addr = $urandom;
    send($urandom_range(1) ? CMD_ALLOC : CMD_FREE, sz, addr);
  endtask

  // Configure a random setting with small sizes and counts.
  task automatic random_setting(input logic [3:0] mask);
    for (int p = 0; p < 4; p++)
      write_reg(REG_DESC0 + CFG_IDX_W'(p), {32'($urandom), 16'(8 << p) + 16'($urandom_range(4)),
                16'($urandom_range(1, 70))});
    write_reg(REG_ENABLE, 64'(mask));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Commands with no pool enabled.
    send(CMD_ALLOC, 16'd0, 32'd0);
    send(CMD_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    drain();
    // Directed: saturated count, wrapping base, zero size, full pool.
    write_reg(REG_DESC0, {32'hFFFF_FFF0, 16'd0, 16'd3});
    write_reg(REG_DESC0 + 3'd1, {32'hFFFF_FF00, 16'hFFFF, 16'hFFFF});
    write_reg(REG_DESC0 + 3'd2, {32'h0000_1000, 16'd16, 16'd1});
    write_reg(REG_DESC3, {32'h0, 16'd32, 16'd2});
    write_reg(REG_DESC3 + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ENABLE, 64'hF);
    send(CMD_ALLOC, 16'd0, 32'd0);
    send(CMD_ALLOC, 16'd0, 32'd0);
    send(CMD_FREE, 16'd0, 32'hFFFF_FFF0);
    send(CMD_ALLOC, 16'd1, 32'd0);
    send(CMD_ALLOC, 16'd1, 32'd0);
    send(CMD_FREE, 16'd1, 32'hFFFF_FF00);
    send(CMD_FREE, 16'd1, 32'hFFFF_FF00);
    send(CMD_FREE, 16'd1, 32'hFFFF_FFFF);
    send(CMD_FREE, 16'hFFFF, 32'h0001_0000);
    drain();
    write_reg(REG_ENABLE, 64'b1100);
    send(CMD_ALLOC, 16'd16, 32'd0);
    send(CMD_ALLOC, 16'd16, 32'd0);
    send(CMD_FREE, 16'd16, 32'h0000_100F);
    send(CMD_FREE, 16'd16, 32'h0000_1010);
    send(CMD_ALLOC, 16'd32, 32'd0);
    send(CMD_FREE, 16'd32, 32'h0000_0020);
    send(CMD_ALLOC, 16'd33, 32'd0);
    drain();
    write_reg(REG_ENABLE, 64'h0);
    // Random phases over several settings and idle rates.
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph < 3) ? 13 : (ph < 6) ? 70 : 0;
      random_setting((ph == 7) ? 4'hF : 4'($urandom_range(1, 15)));
      for (int i = 0; i < 100; i++) random_request();
      drain();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== size_class_block_pool_allocator.f =====
+incdir+rtl
rtl/scbpa_pkg.sv
rtl/scbpa_ctrl.sv
rtl/scbpa_dp.sv
rtl/size_class_block_pool_allocator.sv
tb/scbpa_checker.sv
tb/tb_size_class_block_pool_allocator.sv
